FILE: hdl/wmx_pkg.sv
// Shared types, constants and the strip map for the LED matrix serializer.
// No dependencies; every other file in hdl/ imports this package.
package wmx_pkg;

  localparam int WMX_LED_COUNT = 32;
  localparam int WMX_ROWS      = 8;
  localparam int WMX_COLS      = 4;

  localparam int BITS_PER_LED  = 24;
  localparam int MAP_ROWS      = 8;
  localparam int MAP_COLS      = 4;
  localparam int CfgIdxW       = 2;
  localparam int CfgDataW      = 8;

  localparam logic [7:0] DUTY_ZERO_RST   = 8'd16;
  localparam logic [7:0] DUTY_ONE_RST    = 8'd32;
  localparam logic [5:0] RESET_SLOTS_RST = 6'd1;

  // Strip position of each matrix cell, indexed [row][column].
  localparam logic [4:0] STRIP_MAP [MAP_ROWS][MAP_COLS] = '{
    '{5'd31, 5'd27, 5'd23, 5'd19},
    '{5'd30, 5'd26, 5'd22, 5'd18},
    '{5'd29, 5'd25, 5'd21, 5'd17},
    '{5'd28, 5'd24, 5'd20, 5'd16},
    '{5'd15, 5'd11, 5'd7,  5'd3 },
    '{5'd14, 5'd10, 5'd6,  5'd2 },
    '{5'd13, 5'd9,  5'd5,  5'd1 },
    '{5'd12, 5'd8,  5'd4,  5'd0 }
  };

  typedef enum logic [1:0] {
    ACT_SET_LED   = 2'd0,
    ACT_CLEAR_ALL = 2'd1,
    ACT_START     = 2'd2,
    ACT_TICK      = 2'd3
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DUTY_ZERO   = 2'd0,
    REG_DUTY_ONE    = 2'd1,
    REG_RESET_SLOTS = 2'd2
  } reg_idx_e;

  typedef struct packed {
    action_e    action;
    logic [3:0] row;
    logic [2:0] column;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } cmd_t;

  typedef struct packed {
    logic [7:0] duty;
    logic       frame_last;
    logic       busy_res;
    logic       accepted;
  } result_t;

  typedef struct packed {
    logic [7:0] duty_zero;
    logic [7:0] duty_one;
    logic [5:0] reset_slots;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic tick;
  } frame_ctrl_t;

  typedef struct packed {
    logic [7:0] duty;
    logic       frame_last;
    logic       active;       // frame in flight before this item
    logic       active_next;  // frame in flight after this item
  } frame_stat_t;

endpackage

FILE: hdl/ws2812_matrix_serializer.sv
// Top level of the LED matrix serializer: command and config ports, pixel
// store, input and result registers. Depends on wmx_pkg and wmx_frame.
//
//  Channel  | Handshake             | Payload
//  ---------+-----------------------+--------------------------------------
//  command  | start_i, busy_o       | cmd_i (action, row, column, r, g, b)
//  result   | done_o (one cycle)    | result_o (duty, frame_last, busy, acc)
//  config   | cfg_we_i              | cfg_idx_i, cfg_data_i
//
// One item is taken every cycle; busy_o stays low. An item accepted at one
// edge is registered, processed in the next cycle, and its result shows on
// result_o from a register, with done_o high for one cycle.
// rst_ni clears control state, registers to their reset values and the
// pixel store. The receiver cannot stall; each result is there for one cycle.
module ws2812_matrix_serializer #(
  parameter int LED_COUNT = wmx_pkg::WMX_LED_COUNT,
  parameter int ROWS      = wmx_pkg::WMX_ROWS,
  parameter int COLS      = wmx_pkg::WMX_COLS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  wmx_pkg::cmd_t                  cmd_i,
  output logic                           busy_o,
  output logic                           done_o,
  output wmx_pkg::result_t               result_o,
  input  logic                           cfg_we_i,
  input  logic [wmx_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [wmx_pkg::CfgDataW-1:0]   cfg_data_i
);
  import wmx_pkg::*;

  localparam int PosCmpW = 10;

  cmd_t        in_q;
  logic        in_vld_q;
  result_t     res_q, res_d;
  logic        res_vld_q;
  cfg_t        cfg_q;
  logic [23:0] pixel_q [LED_COUNT];

  frame_ctrl_t frame_ctrl;
  frame_stat_t frame_stat;
  logic [4:0]  pos;
  logic        coord_ok;
  logic        set_ok;
  logic        clear_all;
  logic [23:0] grb_word;

  assign busy_o   = 1'b0;
  assign done_o   = res_vld_q;
  assign result_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.duty_zero   <= DUTY_ZERO_RST;
      cfg_q.duty_one    <= DUTY_ONE_RST;
      cfg_q.reset_slots <= RESET_SLOTS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DUTY_ZERO:   cfg_q.duty_zero   <= cfg_data_i;
        REG_DUTY_ONE:    cfg_q.duty_one    <= cfg_data_i;
        REG_RESET_SLOTS: cfg_q.reset_slots <= cfg_data_i[5:0];
        default:         cfg_q             <= cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= start_i && !busy_o;
      res_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      in_q <= cmd_i;
    end
    if (in_vld_q) begin
      res_q <= res_d;
    end
  end

  // The matrix map is only 8x4, so both the configured size and the map
  // bound the coordinate, and the mapped position must fit the strip.
  assign pos      = STRIP_MAP[in_q.row[2:0]][in_q.column[1:0]];
  assign coord_ok = ({1'b0, in_q.row} < 5'(ROWS)) && ({1'b0, in_q.column} < 4'(COLS))
                 && (in_q.row < 4'(MAP_ROWS)) && (in_q.column < 3'(MAP_COLS))
                 && ({5'b0, pos} < PosCmpW'(LED_COUNT));
  assign set_ok    = in_vld_q && (in_q.action == ACT_SET_LED) && coord_ok;
  assign clear_all = in_vld_q && (in_q.action == ACT_CLEAR_ALL);
  assign grb_word  = {in_q.green, in_q.red, in_q.blue};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LED_COUNT; i++) begin
        pixel_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < LED_COUNT; i++) begin
        if (clear_all) begin
          pixel_q[i] <= '0;
        end else if (set_ok && ({5'b0, pos} == PosCmpW'(i))) begin
          pixel_q[i] <= grb_word;
        end
      end
    end
  end

  assign frame_ctrl.start = in_vld_q && (in_q.action == ACT_START);
  assign frame_ctrl.tick  = in_vld_q && (in_q.action == ACT_TICK);

  wmx_frame #(
    .LED_COUNT (LED_COUNT)
  ) u_frame (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (frame_ctrl),
    .cfg_i    (cfg_q),
    .pixels_i (pixel_q),
    .stat_o   (frame_stat)
  );

  always_comb begin
    res_d.duty       = frame_stat.duty;
    res_d.frame_last = frame_stat.frame_last;
    res_d.busy_res   = frame_stat.active_next;
    res_d.accepted   = 1'b1;
    case (in_q.action)
      ACT_SET_LED: res_d.accepted = coord_ok;
      ACT_START:   res_d.accepted = !frame_stat.active;
      default:     res_d.accepted = 1'b1;
    endcase
  end

  a_result_follows_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q |=> done_o)
    else $error("item processed without a result strobe");

  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |=> !done_o)
    else $error("result strobe without an item");

  a_last_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.frame_last |-> !result_o.busy_res)
    else $error("final slot reported while still busy");

endmodule

FILE: hdl/wmx_frame.sv
// Frame snapshot and slot sequencer: latches the pixels and duties at start
// and walks LEDs, GRB bits and trailing latch slots, one slot per tick.
// Depends on wmx_pkg.
module wmx_frame #(
  parameter int LED_COUNT = wmx_pkg::WMX_LED_COUNT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  wmx_pkg::frame_ctrl_t  ctrl_i,
  input  wmx_pkg::cfg_t         cfg_i,
  input  logic [23:0]           pixels_i [LED_COUNT],
  output wmx_pkg::frame_stat_t  stat_o
);
  import wmx_pkg::*;

  localparam int LedW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam logic [LedW-1:0] LastLed = LedW'(LED_COUNT - 1);
  localparam logic [4:0] BitTop = 5'(BITS_PER_LED - 1);

  logic [23:0]     snap_q [LED_COUNT];
  logic            sending_q, sending_d;
  logic            pix_q, pix_d;
  logic [LedW-1:0] led_q, led_d;
  logic [4:0]      bit_q, bit_d;
  logic [5:0]      tail_q, tail_d;
  logic [7:0]      lat_zero_q, lat_one_q;
  logic [5:0]      lat_rs_q;
  logic [23:0]     word;
  logic            take_start;
  logic            do_tick;
  logic            last;

  assign take_start = ctrl_i.start && !sending_q;
  assign do_tick    = ctrl_i.tick && sending_q;
  assign word       = snap_q[led_q];

  // Next state of the slot walk.
  always_comb begin
    sending_d = sending_q;
    pix_d     = pix_q;
    led_d     = led_q;
    bit_d     = bit_q;
    tail_d    = tail_q;
    last      = 1'b0;
    if (take_start) begin
      sending_d = 1'b1;
      pix_d     = 1'b1;
      led_d     = '0;
      bit_d     = BitTop;
      tail_d    = '0;
    end else if (do_tick) begin
      if (pix_q) begin
        if (bit_q != 5'd0) begin
          bit_d = bit_q - 5'd1;
        end else if (led_q != LastLed) begin
          bit_d = BitTop;
          led_d = led_q + LedW'(1);
        end else if (lat_rs_q == 6'd0) begin
          last = 1'b1;
        end else begin
          pix_d  = 1'b0;
          tail_d = lat_rs_q;
        end
      end else if (tail_q == 6'd1) begin
        last = 1'b1;
      end else begin
        tail_d = tail_q - 6'd1;
      end
      if (last) begin
        sending_d = 1'b0;
        pix_d     = 1'b0;
      end
    end
  end

  // Result of the current item.
  always_comb begin
    stat_o.duty        = 8'd0;
    stat_o.frame_last  = last;
    stat_o.active      = sending_q;
    stat_o.active_next = sending_d;
    if (do_tick && pix_q) begin
      stat_o.duty = word[bit_q] ? lat_one_q : lat_zero_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sending_q <= 1'b0;
      pix_q     <= 1'b0;
      led_q     <= '0;
      bit_q     <= '0;
      tail_q    <= '0;
    end else begin
      sending_q <= sending_d;
      pix_q     <= pix_d;
      led_q     <= led_d;
      bit_q     <= bit_d;
      tail_q    <= tail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_start) begin
      snap_q     <= pixels_i;
      lat_zero_q <= cfg_i.duty_zero;
      lat_one_q  <= cfg_i.duty_one;
      lat_rs_q   <= cfg_i.reset_slots;
    end
  end

  a_last_only_when_sending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last |-> sending_q && ctrl_i.tick)
    else $error("frame_last raised without a frame in flight");

  a_tail_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sending_q && !pix_q |-> tail_q != 6'd0)
    else $error("latch slot counter empty during latch slots");

  a_bit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sending_q && pix_q |-> bit_q <= BitTop)
    else $error("bit counter out of range");

  a_end_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(sending_q) |-> $past(ctrl_i.tick))
    else $error("frame ended without a tick");

endmodule

FILE: tb/ws2812_slot_checker.sv
`timescale 1ns / 100ps
// Checker for ws2812_matrix_serializer: watches the command, result and register
// ports, predicts the result of every accepted item and compares it field by field.
// Depends on wmx_pkg for the payload types, register indexes and reset values.
module ws2812_slot_checker
  import wmx_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  logic                cmd_busy_i,
  input  cmd_t                cmd_i,
  input  logic                res_valid_i,
  input  result_t             res_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  errors_o,
  output int                  outstanding_o
);

  localparam int FRAME_BITS = WMX_LED_COUNT * BITS_PER_LED;
  localparam int LedIdxW    = $clog2(WMX_LED_COUNT);

  logic [23:0] pixels       [WMX_LED_COUNT];
  logic [23:0] frame_pixels [WMX_LED_COUNT];
  logic        sending;
  logic [9:0]  slot_idx;
  logic [9:0]  frame_len;
  logic [7:0]  duty_zero_reg;
  logic [7:0]  duty_one_reg;
  logic [5:0]  slots_reg;
  logic [7:0]  lat_zero;
  logic [7:0]  lat_one;

  result_t expected_slots [$];

  task automatic report_mismatch(input string msg);
    $display("%0t ns: slot mismatch: %s", $time, msg);
    errors_o++;
  endtask

  // Applies one item to the predicted state and returns the result it causes.
  function automatic result_t next_slot(input cmd_t c);
    result_t     r;
    int          pos;
    int          slot;
    logic [23:0] word;
    r = '0;
    r.accepted = 1'b1;
    slot = int'(slot_idx);
    case (c.action)
      ACT_SET_LED: begin
        if (int'(c.row) >= WMX_ROWS || int'(c.column) >= WMX_COLS ||
            int'(c.row) >= MAP_ROWS || int'(c.column) >= MAP_COLS) begin
          r.accepted = 1'b0;
        end else begin
          // Rows 0-3 cover strip positions 31 down to 16, rows 4-7 cover 15 down
          // to 0; each row steps down by one and each column by four.
          pos = (int'(c.row) < 4 ? 31 : 19) - int'(c.row) - 4 * int'(c.column);
          if (pos >= WMX_LED_COUNT) begin
            r.accepted = 1'b0;
          end else begin
            pixels[LedIdxW'(pos)] = {c.green, c.red, c.blue};
          end
        end
      end
      ACT_CLEAR_ALL: begin
        pixels = '{default: '0};
      end
      ACT_START: begin
        if (sending) begin
          r.accepted = 1'b0;
        end else begin
          frame_pixels = pixels;
          lat_zero     = duty_zero_reg;
          lat_one      = duty_one_reg;
          frame_len    = 10'(FRAME_BITS + int'(slots_reg));
          slot_idx     = '0;
          sending      = 1'b1;
        end
      end
      ACT_TICK: begin
        if (sending) begin
          if (slot < FRAME_BITS) begin
            word   = frame_pixels[LedIdxW'(slot / BITS_PER_LED)];
            r.duty = word[5'(BITS_PER_LED - 1 - slot % BITS_PER_LED)] ? lat_one : lat_zero;
          end
          if (slot + 1 >= int'(frame_len)) begin
            r.frame_last = 1'b1;
            sending      = 1'b0;
            slot_idx     = '0;
          end else begin
            slot_idx++;
          end
        end
      end
      default: ;
    endcase
    r.busy_res = sending;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      pixels        = '{default: '0};
      frame_pixels  = '{default: '0};
      sending       = 1'b0;
      slot_idx      = '0;
      frame_len     = '0;
      duty_zero_reg = DUTY_ZERO_RST;
      duty_one_reg  = DUTY_ONE_RST;
      slots_reg     = RESET_SLOTS_RST;
      lat_zero      = '0;
      lat_one       = '0;
      expected_slots.delete();
      errors_o      = 0;
      outstanding_o = 0;
    end else begin
      if (res_valid_i) begin
        if (expected_slots.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected (duty %0d)", res_i.duty));
        end else begin
          want = expected_slots.pop_front();
          if (res_i.duty !== want.duty)
            report_mismatch($sformatf("duty expected %0d, got %0d", want.duty, res_i.duty));
          if (res_i.frame_last !== want.frame_last)
            report_mismatch($sformatf("frame_last expected %0b, got %0b",
                                      want.frame_last, res_i.frame_last));
          if (res_i.busy_res !== want.busy_res)
            report_mismatch($sformatf("busy_res expected %0b, got %0b",
                                      want.busy_res, res_i.busy_res));
          if (res_i.accepted !== want.accepted)
            report_mismatch($sformatf("accepted expected %0b, got %0b",
                                      want.accepted, res_i.accepted));
        end
      end
      // Register writes only land at the next start, so they are simply stored.
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_DUTY_ZERO:   duty_zero_reg = cfg_data_i;
          REG_DUTY_ONE:    duty_one_reg  = cfg_data_i;
          REG_RESET_SLOTS: slots_reg     = cfg_data_i[5:0];
          default: ;
        endcase
      end
      if (cmd_valid_i && !cmd_busy_i) begin
        expected_slots.push_back(next_slot(cmd_i));
      end
      outstanding_o = expected_slots.size();
    end
  end

endmodule

FILE: tb/tb_ws2812_matrix_serializer.sv
`timescale 1ns / 100ps
// Testbench top for ws2812_matrix_serializer: clock, reset, command and register
// stimulus, and the verdict. Depends on wmx_pkg and ws2812_slot_checker.
module tb_ws2812_matrix_serializer;
  import wmx_pkg::*;

  localparam int RUN_LIMIT  = 100000;
  localparam int FRAME_BITS = WMX_LED_COUNT * BITS_PER_LED;

  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                start_i    = 1'b0;
  cmd_t                cmd_i      = '0;
  logic                busy_o;
  logic                done_o;
  result_t             result_o;
  logic                cfg_we_i   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i  = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  int errors;
  int outstanding;
  int idle_pct    = 0;
  int slots_set   = int'(RESET_SLOTS_RST);
  int frame_len   = 0;
  int frame_ticks = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  ws2812_matrix_serializer dut (
    .clk_i,
    .rst_ni,
    .start_i,
    .cmd_i,
    .busy_o,
    .done_o,
    .result_o,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i
  );

  ws2812_slot_checker slot_checker (
    .clk_i,
    .rst_ni,
    .cmd_valid_i   (start_i),
    .cmd_busy_i    (busy_o),
    .cmd_i,
    .res_valid_i   (done_o),
    .res_i         (result_o),
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .errors_o      (errors),
    .outstanding_o (outstanding)
  );

  function automatic cmd_t rand_cmd(input action_e act, input bit in_map);
    cmd_t c;
    c.action = act;
    c.row    = in_map ? 4'($urandom_range(0, WMX_ROWS - 1)) : 4'($urandom_range(0, 15));
    c.column = in_map ? 3'($urandom_range(0, WMX_COLS - 1)) : 3'($urandom_range(0, 7));
    c.red    = 8'($urandom);
    c.green  = 8'($urandom);
    c.blue   = 8'($urandom);
    return c;
  endfunction

  function automatic cmd_t led(input logic [3:0] row, input logic [2:0] column,
                               input logic [7:0] red, input logic [7:0] green,
                               input logic [7:0] blue);
    cmd_t c;
    c.action = ACT_SET_LED;
    c.row    = row;
    c.column = column;
    c.red    = red;
    c.green  = green;
    c.blue   = blue;
    return c;
  endfunction

  task automatic send_cmd(input cmd_t c);
    while ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    cmd_i   <= c;
    do @(posedge clk_i); while (busy_o);
    if (c.action == ACT_TICK) frame_ticks++;
  endtask

  task automatic start_frame();
    send_cmd(rand_cmd(ACT_START, 1'b0));
    frame_len   = FRAME_BITS + slots_set;
    frame_ticks = 0;
  endtask

  task automatic fill_pixels(input int count);
    repeat (count) send_cmd(rand_cmd(ACT_SET_LED, $urandom_range(0, 3) != 0));
  endtask

  // Ticks with other items mixed in; starts here land while a frame is in flight.
  task automatic run_ticks(input int upto);
    int pick;
    while (frame_ticks < upto) begin
      pick = $urandom_range(0, 99);
      if (pick < 6)       send_cmd(rand_cmd(ACT_SET_LED, pick < 4));
      else if (pick < 9)  send_cmd(rand_cmd(ACT_CLEAR_ALL, 1'b0));
      else if (pick < 13) send_cmd(rand_cmd(ACT_START, 1'b0));
      else                send_cmd(rand_cmd(ACT_TICK, 1'b0));
    end
    if (frame_ticks >= frame_len) begin
      repeat (3) send_cmd(rand_cmd(ACT_TICK, 1'b0));
      send_cmd(rand_cmd(ACT_SET_LED, 1'b0));
    end
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [7:0] d0, input logic [7:0] d1,
                            input logic [5:0] slots);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_DUTY_ZERO;
    cfg_data_i <= d0;
    @(posedge clk_i);
    cfg_idx_i  <= REG_DUTY_ONE;
    cfg_data_i <= d1;
    @(posedge clk_i);
    cfg_idx_i  <= REG_RESET_SLOTS;
    cfg_data_i <= CfgDataW'(slots);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    slots_set  = int'(slots);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed items at the reset register values.
    send_cmd(rand_cmd(ACT_TICK, 1'b0));
    send_cmd(led(4'd0, 3'd0, 8'hFF, 8'h00, 8'hFF));
    send_cmd(led(4'd7, 3'd3, 8'h00, 8'hFF, 8'h00));
    send_cmd(led(4'd3, 3'd3, 8'h80, 8'h01, 8'h7F));
    send_cmd(led(4'd4, 3'd0, 8'hAA, 8'h55, 8'hC3));
    send_cmd(led(4'd8, 3'd0, 8'h12, 8'h34, 8'h56));
    send_cmd(led(4'd0, 3'd4, 8'h12, 8'h34, 8'h56));
    send_cmd(led(4'd15, 3'd7, 8'hFF, 8'hFF, 8'hFF));
    send_cmd(rand_cmd(ACT_CLEAR_ALL, 1'b0));
    send_cmd(rand_cmd(ACT_TICK, 1'b0));
    send_cmd(led(4'd0, 3'd0, 8'hFF, 8'hFF, 8'hFF));
    send_cmd(led(4'd7, 3'd3, 8'h5A, 8'hA5, 8'hF0));
    send_cmd(led(4'd7, 3'd0, 8'h00, 8'hFF, 8'h01));
    start_frame();
    send_cmd(rand_cmd(ACT_START, 1'b0));
    send_cmd(rand_cmd(ACT_TICK, 1'b0));
    send_cmd(rand_cmd(ACT_TICK, 1'b0));
    // Store changes while sending must not reach the frame in flight.
    send_cmd(led(4'd7, 3'd3, 8'hFF, 8'hFF, 8'hFF));
    send_cmd(rand_cmd(ACT_CLEAR_ALL, 1'b0));
    send_cmd(rand_cmd(ACT_TICK, 1'b0));
    run_ticks(300);

    // These values only apply from the next start on.
    idle_pct = 66;
    write_regs(8'd0, 8'd255, 6'd0);
    run_ticks(frame_len);
    fill_pixels(20);
    start_frame();
    run_ticks(300);
    write_regs(8'd255, 8'd0, 6'd63);

    idle_pct = 13;
    run_ticks(frame_len);
    send_cmd(rand_cmd(ACT_CLEAR_ALL, 1'b0));
    fill_pixels(24);
    start_frame();
    run_ticks(40);

    drain();
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_ws2812_matrix_serializer OK");
    end else begin
      $display("tb_ws2812_matrix_serializer NOT OK");
    end
    $finish;
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < RUN_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb_ws2812_matrix_serializer NOT OK");
    $finish;
  end

endmodule
